[design/sba_pkg.sv]
// Package for the slab bitmap allocator: sizes, list tags, result codes,
// datapath op codes, request/response/command/status types, helper functions.
// No dependencies.
package sba_pkg;

    localparam int NUM_BLOCKS = 64;
    localparam int MAX_SLOTS  = 64;
    localparam int MIN_SLOTS  = 32;
    localparam int TRIM_MIN   = 4;

    localparam int BLK_W  = $clog2(NUM_BLOCKS);
    localparam int LINK_W = BLK_W + 1;
    localparam int CNT_W  = $clog2(NUM_BLOCKS + 1);
    localparam int MAP_W  = MAX_SLOTS;
    localparam int SLOT_W = 6;
    localparam int OPB_W  = 7;

    localparam logic [LINK_W-1:0] NIL = LINK_W'(NUM_BLOCKS);

    // list tags
    localparam logic [1:0] TAG_UNUSED  = 2'd0;
    localparam logic [1:0] TAG_PARTIAL = 2'd1;
    localparam logic [1:0] TAG_EMPTY   = 2'd2;
    localparam logic [1:0] TAG_FULL    = 2'd3;

    // result status
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOMEM   = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;

    // datapath operations
    localparam logic [3:0] OP_NONE      = 4'd0;
    localparam logic [3:0] OP_CLEAR     = 4'd1;
    localparam logic [3:0] OP_LATCH     = 4'd2;
    localparam logic [3:0] OP_ALLOC_SEL = 4'd3;
    localparam logic [3:0] OP_ALLOC_PICK= 4'd4;
    localparam logic [3:0] OP_ALLOC_WB  = 4'd5;
    localparam logic [3:0] OP_FREE_RD   = 4'd6;
    localparam logic [3:0] OP_FREE_CHK  = 4'd7;
    localparam logic [3:0] OP_MV_RD     = 4'd8;
    localparam logic [3:0] OP_MV_UNLINK = 4'd9;
    localparam logic [3:0] OP_MV_PUSH   = 4'd10;
    localparam logic [3:0] OP_MV_FIX    = 4'd11;
    localparam logic [3:0] OP_DONE      = 4'd12;

    // register index
    localparam logic REG_OPB = 1'b0;

    typedef struct packed {
        logic              mode;
        logic [BLK_W-1:0]  block_index;
        logic [SLOT_W-1:0] slot_index;
    } req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [BLK_W-1:0]  granted_block;
        logic [SLOT_W-1:0] granted_slot;
        logic              block_released;
    } rsp_t;

    typedef struct packed {
        logic [3:0] op;
    } cmd_t;

    typedef struct packed {
        logic partial_avail;
        logic fresh_avail;
        logic bm_zero;
        logic free_move;
        logic clr_last;
        logic rsp_hold;
    } stat_t;

    function automatic logic [OPB_W-1:0] clamp_slots(input logic [OPB_W-1:0] v);
        logic [OPB_W-1:0] n;
        n = v;
        if (v > OPB_W'(MAX_SLOTS)) n = OPB_W'(MAX_SLOTS);
        if (v < OPB_W'(MIN_SLOTS)) n = OPB_W'(MIN_SLOTS);
        return n;
    endfunction

    function automatic logic [MAP_W-1:0] slot_mask(input logic [OPB_W-1:0] n);
        logic [MAP_W-1:0] m;
        for (int i = 0; i < MAP_W; i++) begin
            m[i] = (32'(i) < 32'(n));
        end
        return m;
    endfunction

    // lowest set bit, 0 for an all-zero word
    function automatic logic [SLOT_W-1:0] lowest_one(input logic [MAP_W-1:0] v);
        logic [SLOT_W-1:0] idx;
        idx = '0;
        for (int i = MAP_W - 1; i >= 0; i--) begin
            if (v[i]) idx = SLOT_W'(i);
        end
        return idx;
    endfunction

endpackage

[design/slab_bitmap_allocator_unit.sv]
// Slab allocator over NUM_BLOCKS blocks, one request at a time.
// Steps: free = latch, read, check, done; partial alloc = latch, select, pick,
// write back, done; out of memory = latch, select, done; a list move adds read,
// unlink, push and fix. A new request is taken only in the idle state, after the
// sequencer's serial reads and writes of the registered-read memories end.
// Reset: async rst_n; then a pass over all blocks initializes the link lists.
module slab_bitmap_allocator_unit
    import sba_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // request channel
    input  logic        req_valid,
    output logic        req_stall,
    input  req_t        req,
    // response channel
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output rsp_t        rsp,
    // config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Controller: one op per cycle unless stalled; datapath: decision flags.
    cmd_t  cmd;
    stat_t stat;

    sba_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_mode  (req.mode),
        .req_stall (req_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Datapath: memories, list heads/counts, config and response register.
    // The response register lets a new request in while a result waits.
    sba_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .req       (req),
        .rsp       (rsp),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

endmodule

[design/sba_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[design/sba_datapath.sv]
// Allocator datapath: bitmap/link/tag memories, list heads and counts,
// config register and response register. Uses sba_pkg and sba_ram.
module sba_datapath
    import sba_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output stat_t       stat,
    input  req_t        req,
    output rsp_t        rsp,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [OPB_W-1:0]  opb_reg;
    logic [BLK_W-1:0]  clr_reg;
    logic [BLK_W-1:0]  blk_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [BLK_W-1:0]  b_reg;
    logic [1:0]        old_tag_reg, new_tag_reg;
    logic [LINK_W-1:0] h_reg;
    logic [MAP_W-1:0]  bm_reg;
    logic [SLOT_W-1:0] gs_reg;
    logic [BLK_W-1:0]  gb_reg;
    logic [1:0]        st_reg;
    logic              rel_reg;
    rsp_t              rsp_reg;
    logic              rsp_valid_reg;
    logic [LINK_W-1:0] ph_reg, eh_reg, fh_reg, uh_reg;
    logic [CNT_W-1:0]  pc_reg, ec_reg, fc_reg;

    // memories
    logic              bm_we, tg_we, nx_we, pv_we;
    logic [BLK_W-1:0]  bm_waddr, tg_waddr, nx_waddr, pv_waddr;
    logic [BLK_W-1:0]  bm_raddr, tg_raddr, nx_raddr, pv_raddr;
    logic [MAP_W-1:0]  bm_wdata, bm_rdata;
    logic [1:0]        tg_wdata, tg_rdata;
    logic [LINK_W-1:0] nx_wdata, nx_rdata, pv_wdata, pv_rdata;

    sba_ram #(.WIDTH(MAP_W), .DEPTH(NUM_BLOCKS)) u_bm (
        .clk(clk), .we(bm_we), .waddr(bm_waddr), .wdata(bm_wdata),
        .raddr(bm_raddr), .rdata(bm_rdata)
    );
    sba_ram #(.WIDTH(2), .DEPTH(NUM_BLOCKS)) u_tag (
        .clk(clk), .we(tg_we), .waddr(tg_waddr), .wdata(tg_wdata),
        .raddr(tg_raddr), .rdata(tg_rdata)
    );
    sba_ram #(.WIDTH(LINK_W), .DEPTH(NUM_BLOCKS)) u_next (
        .clk(clk), .we(nx_we), .waddr(nx_waddr), .wdata(nx_wdata),
        .raddr(nx_raddr), .rdata(nx_rdata)
    );
    sba_ram #(.WIDTH(LINK_W), .DEPTH(NUM_BLOCKS)) u_prev (
        .clk(clk), .we(pv_we), .waddr(pv_waddr), .wdata(pv_wdata),
        .raddr(pv_raddr), .rdata(pv_rdata)
    );

    logic [OPB_W-1:0]  slots;
    logic [MAP_W-1:0]  mask;
    logic              partial_avail, fresh_avail, from_empty;
    logic [BLK_W-1:0]  fresh_b;
    logic [SLOT_W-1:0] low_idx;
    logic [MAP_W-1:0]  bm_clr, free_bm;
    logic              invalid, all_free, trim;
    logic [LINK_W-1:0] head_new;
    logic              cfg_wr;

    assign slots         = clamp_slots(opb_reg);
    assign mask          = slot_mask(slots);
    assign partial_avail = (ph_reg != NIL);
    assign from_empty    = (eh_reg != NIL);
    assign fresh_avail   = from_empty || (uh_reg != NIL);
    assign fresh_b       = from_empty ? eh_reg[BLK_W-1:0] : uh_reg[BLK_W-1:0];
    assign low_idx       = lowest_one(bm_rdata);
    assign bm_clr        = bm_rdata & ~(MAP_W'(1) << low_idx);
    assign free_bm       = bm_rdata | (MAP_W'(1) << slot_reg);
    assign all_free      = (free_bm == mask);

    assign invalid = ({1'b0, blk_reg} >= NIL) || (tg_rdata == TAG_UNUSED) ||
                     (tg_rdata == TAG_EMPTY) || ({1'b0, slot_reg} >= slots) ||
                     bm_rdata[slot_reg];

    // trim uses counts before the block leaves partial
    assign trim = (ec_reg > CNT_W'(TRIM_MIN)) &&
                  ({2'b00, ec_reg, 2'b00} >
                   ((CNT_W + 4)'(fc_reg) + (CNT_W + 4)'(pc_reg >> 1)));

    always_comb
    begin
        case (new_tag_reg)
            TAG_PARTIAL: head_new = ph_reg;
            TAG_EMPTY:   head_new = eh_reg;
            TAG_FULL:    head_new = fh_reg;
            default:     head_new = uh_reg;
        endcase
    end

    assign stat.partial_avail = partial_avail;
    assign stat.fresh_avail   = fresh_avail;
    assign stat.bm_zero       = (bm_reg == '0);
    assign stat.free_move     = !invalid && ((tg_rdata == TAG_FULL) || all_free);
    assign stat.clr_last      = (clr_reg == BLK_W'(NUM_BLOCKS - 1));
    assign stat.rsp_hold      = rsp_valid_reg && rsp_stall;

    // memory port control
    always_comb
    begin
        bm_we = 1'b0; bm_waddr = b_reg; bm_wdata = bm_reg; bm_raddr = b_reg;
        tg_we = 1'b0; tg_waddr = b_reg; tg_wdata = new_tag_reg; tg_raddr = b_reg;
        nx_we = 1'b0; nx_waddr = b_reg; nx_wdata = head_new; nx_raddr = b_reg;
        pv_we = 1'b0; pv_waddr = b_reg; pv_wdata = NIL; pv_raddr = b_reg;
        case (cmd.op)
            OP_CLEAR:
            begin
                nx_we = 1'b1; nx_waddr = clr_reg; nx_wdata = {1'b0, clr_reg} + 1'b1;
                pv_we = 1'b1; pv_waddr = clr_reg;
                pv_wdata = (clr_reg == '0) ? NIL : {1'b0, clr_reg} - 1'b1;
                tg_we = 1'b1; tg_waddr = clr_reg; tg_wdata = TAG_UNUSED;
            end
            OP_ALLOC_SEL:
            begin
                bm_raddr = ph_reg[BLK_W-1:0];
                if (!partial_avail && fresh_avail)
                begin
                    bm_we = 1'b1; bm_waddr = fresh_b; bm_wdata = mask & (mask - 1'b1);
                end
            end
            OP_ALLOC_WB:
            begin
                bm_we = 1'b1;
            end
            OP_FREE_RD:
            begin
                bm_raddr = blk_reg;
                tg_raddr = blk_reg;
            end
            OP_FREE_CHK:
            begin
                bm_we = !invalid; bm_wdata = free_bm;
            end
            OP_MV_UNLINK:
            begin
                nx_we = (pv_rdata != NIL); nx_waddr = pv_rdata[BLK_W-1:0];
                nx_wdata = nx_rdata;
                pv_we = (nx_rdata != NIL); pv_waddr = nx_rdata[BLK_W-1:0];
                pv_wdata = pv_rdata;
            end
            OP_MV_PUSH:
            begin
                nx_we = 1'b1;
                pv_we = 1'b1;
                tg_we = 1'b1;
            end
            OP_MV_FIX:
            begin
                pv_we = (h_reg != NIL); pv_waddr = h_reg[BLK_W-1:0];
                pv_wdata = {1'b0, b_reg};
            end
            default:
            begin
            end
        endcase
    end

    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_OPB);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            opb_reg       <= OPB_W'(MAX_SLOTS);
            clr_reg       <= '0;
            rsp_valid_reg <= 1'b0;
            ph_reg        <= NIL;
            eh_reg        <= NIL;
            fh_reg        <= NIL;
            uh_reg        <= '0;
            pc_reg        <= '0;
            ec_reg        <= '0;
            fc_reg        <= '0;
        end
        else
        begin
            if (cfg_wr)
            begin
                opb_reg <= pwdata[OPB_W-1:0];
            end
            if (rsp_valid_reg && !rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
            case (cmd.op)
                OP_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                end
                OP_ALLOC_SEL:
                begin
                    if (!partial_avail && fresh_avail)
                    begin
                        if (from_empty)
                        begin
                            ec_reg <= ec_reg - 1'b1;
                        end
                        pc_reg <= pc_reg + 1'b1;
                    end
                end
                OP_ALLOC_WB:
                begin
                    if (bm_reg == '0)
                    begin
                        pc_reg <= pc_reg - 1'b1;
                        fc_reg <= fc_reg + 1'b1;
                    end
                end
                OP_FREE_CHK:
                begin
                    if (!invalid)
                    begin
                        if (tg_rdata == TAG_FULL)
                        begin
                            fc_reg <= fc_reg - 1'b1;
                            pc_reg <= pc_reg + 1'b1;
                        end
                        else if (all_free)
                        begin
                            if (!trim)
                            begin
                                ec_reg <= ec_reg + 1'b1;
                            end
                            pc_reg <= pc_reg - 1'b1;
                        end
                    end
                end
                OP_MV_UNLINK:
                begin
                    if (pv_rdata == NIL)
                    begin
                        case (old_tag_reg)
                            TAG_PARTIAL: ph_reg <= nx_rdata;
                            TAG_EMPTY:   eh_reg <= nx_rdata;
                            TAG_FULL:    fh_reg <= nx_rdata;
                            default:     uh_reg <= nx_rdata;
                        endcase
                    end
                end
                OP_MV_PUSH:
                begin
                    case (new_tag_reg)
                        TAG_PARTIAL: ph_reg <= {1'b0, b_reg};
                        TAG_EMPTY:   eh_reg <= {1'b0, b_reg};
                        TAG_FULL:    fh_reg <= {1'b0, b_reg};
                        default:     uh_reg <= {1'b0, b_reg};
                    endcase
                end
                OP_DONE:
                begin
                    rsp_valid_reg <= 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LATCH:
            begin
                blk_reg  <= req.block_index;
                slot_reg <= req.slot_index;
                st_reg   <= ST_OK;
                gb_reg   <= '0;
                gs_reg   <= '0;
                rel_reg  <= 1'b0;
            end
            OP_ALLOC_SEL:
            begin
                if (partial_avail)
                begin
                    b_reg <= ph_reg[BLK_W-1:0];
                end
                else if (fresh_avail)
                begin
                    b_reg       <= fresh_b;
                    gb_reg      <= fresh_b;
                    old_tag_reg <= from_empty ? TAG_EMPTY : TAG_UNUSED;
                    new_tag_reg <= TAG_PARTIAL;
                end
                else
                begin
                    st_reg <= ST_NOMEM;
                end
            end
            OP_ALLOC_PICK:
            begin
                gs_reg <= low_idx;
                bm_reg <= bm_clr;
            end
            OP_ALLOC_WB:
            begin
                gb_reg      <= b_reg;
                old_tag_reg <= TAG_PARTIAL;
                new_tag_reg <= TAG_FULL;
            end
            OP_FREE_RD:
            begin
                b_reg <= blk_reg;
            end
            OP_FREE_CHK:
            begin
                if (invalid)
                begin
                    st_reg <= ST_INVALID;
                end
                else if (tg_rdata == TAG_FULL)
                begin
                    old_tag_reg <= TAG_FULL;
                    new_tag_reg <= TAG_PARTIAL;
                end
                else
                begin
                    old_tag_reg <= TAG_PARTIAL;
                    new_tag_reg <= trim ? TAG_UNUSED : TAG_EMPTY;
                    rel_reg     <= all_free && trim;
                end
            end
            OP_MV_PUSH:
            begin
                h_reg <= head_new;
            end
            OP_DONE:
            begin
                rsp_reg.status         <= st_reg;
                rsp_reg.granted_block  <= gb_reg;
                rsp_reg.granted_slot   <= gs_reg;
                rsp_reg.block_released <= rel_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == REG_OPB) ? {(32 - OPB_W)'(0), opb_reg} : 32'd0;

endmodule

[design/sba_ctrl.sv]
// Allocator sequencer: steps the datapath through one request at a time.
// Uses sba_pkg.
module sba_ctrl
    import sba_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  req_valid,
    input  logic  req_mode,
    output logic  req_stall,
    input  stat_t stat,
    output cmd_t  cmd
);

    localparam logic [3:0] S_CLEAR   = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_A_SEL   = 4'd2;
    localparam logic [3:0] S_A_PICK  = 4'd3;
    localparam logic [3:0] S_A_WB    = 4'd4;
    localparam logic [3:0] S_F_RD    = 4'd5;
    localparam logic [3:0] S_F_CHK   = 4'd6;
    localparam logic [3:0] S_MV_RD   = 4'd7;
    localparam logic [3:0] S_MV_UNL  = 4'd8;
    localparam logic [3:0] S_MV_PUSH = 4'd9;
    localparam logic [3:0] S_MV_FIX  = 4'd10;
    localparam logic [3:0] S_DONE    = 4'd11;

    logic [3:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.op = OP_CLEAR;
                if (stat.clr_last) state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.op     = OP_LATCH;
                    state_next = req_mode ? S_F_RD : S_A_SEL;
                end
            end
            S_A_SEL:
            begin
                cmd.op = OP_ALLOC_SEL;
                if (stat.partial_avail)    state_next = S_A_PICK;
                else if (stat.fresh_avail) state_next = S_MV_RD;
                else                       state_next = S_DONE;
            end
            S_A_PICK:
            begin
                cmd.op     = OP_ALLOC_PICK;
                state_next = S_A_WB;
            end
            S_A_WB:
            begin
                cmd.op     = OP_ALLOC_WB;
                state_next = stat.bm_zero ? S_MV_RD : S_DONE;
            end
            S_F_RD:
            begin
                cmd.op     = OP_FREE_RD;
                state_next = S_F_CHK;
            end
            S_F_CHK:
            begin
                cmd.op     = OP_FREE_CHK;
                state_next = stat.free_move ? S_MV_RD : S_DONE;
            end
            S_MV_RD:
            begin
                cmd.op     = OP_MV_RD;
                state_next = S_MV_UNL;
            end
            S_MV_UNL:
            begin
                cmd.op     = OP_MV_UNLINK;
                state_next = S_MV_PUSH;
            end
            S_MV_PUSH:
            begin
                cmd.op     = OP_MV_PUSH;
                state_next = S_MV_FIX;
            end
            S_MV_FIX:
            begin
                cmd.op     = OP_MV_FIX;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!stat.rsp_hold)
                begin
                    cmd.op     = OP_DONE;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE);

endmodule

[bench/slab_bitmap_allocator_unit_tb.sv]
// Testbench for slab_bitmap_allocator_unit: random and directed alloc/free requests,
// checked against a predictor of the block lists and slot bitmaps.
// Depends on sba_pkg and the unit RTL.
`timescale 1ns / 100ps

module slab_bitmap_allocator_unit_tb;
    import sba_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_stall;
    req_t        req;
    logic        rsp_valid;
    logic        rsp_stall;
    rsp_t        rsp;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    slab_bitmap_allocator_unit DUT (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_stall(req_stall), .req(req),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    localparam int LIMIT_CYCLES = 400000;

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // ---------------------------------------------------------------
    // Allocator shadow state: bitmaps, doubly linked lists, counts.
    // Null link is NUM_BLOCKS, same as the block.
    // ---------------------------------------------------------------
    logic [MAP_W-1:0]  sh_map [NUM_BLOCKS];
    logic [LINK_W-1:0] sh_next [NUM_BLOCKS];
    logic [LINK_W-1:0] sh_prev [NUM_BLOCKS];
    logic [1:0]        sh_tag [NUM_BLOCKS];
    logic [LINK_W-1:0] sh_head [4];   // indexed by list tag
    int unsigned       n_partial, n_empty, n_full;
    logic [OPB_W-1:0]  sh_opb;

    rsp_t   grant_q[$];     // expected responses, oldest first
    req_t   pending_q[$];   // requests waiting for the driver
    int     mismatches;
    longint cycle_count;

    // live slots, used to steer frees toward valid targets
    int live_blk[$];
    int live_slot[$];

    function automatic int eff_slots();
        int n;
        n = sh_opb;
        if (n > MAX_SLOTS) n = MAX_SLOTS;
        if (n < MIN_SLOTS) n = MIN_SLOTS;
        return n;
    endfunction

    function automatic logic [MAP_W-1:0] all_free_mask();
        int n;
        n = eff_slots();
        if (n >= 64) return '1;
        return (64'd1 << n) - 64'd1;
    endfunction

    task automatic shadow_reset();
        for (int i = 0; i < NUM_BLOCKS; i++)
        begin
            sh_map[i]  = '0;
            sh_next[i] = (i + 1 < NUM_BLOCKS) ? LINK_W'(i + 1) : NIL;
            sh_prev[i] = (i == 0) ? NIL : LINK_W'(i - 1);
            sh_tag[i]  = TAG_UNUSED;
        end
        sh_head[TAG_UNUSED]  = '0;
        sh_head[TAG_PARTIAL] = NIL;
        sh_head[TAG_EMPTY]   = NIL;
        sh_head[TAG_FULL]    = NIL;
        n_partial = 0;
        n_empty   = 0;
        n_full    = 0;
        sh_opb    = OPB_W'(64);
    endtask

    task automatic shadow_unlink(input int b);
        logic [LINK_W-1:0] p, n;
        p = sh_prev[b];
        n = sh_next[b];
        if (p != NIL) sh_next[p] = n;
        else sh_head[sh_tag[b]] = n;
        if (n != NIL) sh_prev[n] = p;
        sh_next[b] = NIL;
        sh_prev[b] = NIL;
    endtask

    task automatic list_push(input logic [1:0] tag, input int b);
        sh_tag[b]  = tag;
        sh_prev[b] = NIL;
        sh_next[b] = sh_head[tag];
        if (sh_head[tag] != NIL) sh_prev[sh_head[tag]] = LINK_W'(b);
        sh_head[tag] = LINK_W'(b);
    endtask

    function automatic int lowest_free(input logic [MAP_W-1:0] v);
        for (int i = 0; i < MAP_W; i++)
            if (v[i]) return i;
        return 0;
    endfunction

    // Apply one request to the shadow state and return its response.
    task automatic allocate_or_free(input req_t r, output rsp_t o);
        logic [MAP_W-1:0] m;
        int b, s;
        m = all_free_mask();
        o = '0;
        o.status = ST_OK;
        if (r.mode == 1'b0)
        begin
            if (sh_head[TAG_PARTIAL] != NIL)
            begin
                b = sh_head[TAG_PARTIAL];
                s = lowest_free(sh_map[b]);
                sh_map[b][s] = 1'b0;
                o.granted_block = BLK_W'(b);
                o.granted_slot  = SLOT_W'(s);
                if (sh_map[b] == '0)
                begin
                    shadow_unlink(b);
                    list_push(TAG_FULL, b);
                    n_partial--;
                    n_full++;
                end
            end
            else if (sh_head[TAG_EMPTY] != NIL || sh_head[TAG_UNUSED] != NIL)
            begin
                b = (sh_head[TAG_EMPTY] != NIL) ? sh_head[TAG_EMPTY] : sh_head[TAG_UNUSED];
                if (sh_tag[b] == TAG_EMPTY) n_empty--;
                shadow_unlink(b);
                sh_map[b] = m & (m - 64'd1);   // slot 0 taken
                list_push(TAG_PARTIAL, b);
                n_partial++;
                o.granted_block = BLK_W'(b);
                o.granted_slot  = '0;
            end
            else
                o.status = ST_NOMEM;
        end
        else
        begin
            b = r.block_index;
            s = r.slot_index;
            if (sh_tag[b] == TAG_UNUSED || sh_tag[b] == TAG_EMPTY ||
                s >= eff_slots() || sh_map[b][s])
                o.status = ST_INVALID;
            else if (sh_tag[b] == TAG_FULL)
            begin
                sh_map[b][s] = 1'b1;
                shadow_unlink(b);
                list_push(TAG_PARTIAL, b);
                n_full--;
                n_partial++;
            end
            else
            begin
                sh_map[b][s] = 1'b1;
                if (sh_map[b] == m)
                begin
                    shadow_unlink(b);
                    // trim rule: hand the block back to the unused pool
                    if (n_empty > TRIM_MIN && n_empty * 4 > n_full + n_partial / 2)
                    begin
                        list_push(TAG_UNUSED, b);
                        o.block_released = 1'b1;
                    end
                    else
                    begin
                        list_push(TAG_EMPTY, b);
                        n_empty++;
                    end
                    n_partial--;
                end
            end
        end
    endtask

    // Stimulus-side bookkeeping of which slots are held, so frees hit them.
    task automatic track_request(input req_t r, input rsp_t o);
        if (r.mode == 1'b0 && o.status == ST_OK)
        begin
            live_blk.push_back(o.granted_block);
            live_slot.push_back(o.granted_slot);
        end
        else if (r.mode == 1'b1 && o.status == ST_OK)
        begin
            for (int i = 0; i < live_blk.size(); i++)
                if (live_blk[i] == r.block_index && live_slot[i] == r.slot_index)
                begin
                    live_blk.delete(i);
                    live_slot.delete(i);
                    break;
                end
        end
    endtask

    // Prediction runs at generation time, since requests are served in order.
    task automatic queue_request(input req_t r);
        rsp_t o;
        allocate_or_free(r, o);
        track_request(r, o);
        pending_q.push_back(r);
        grant_q.push_back(o);
    endtask

    task automatic queue_alloc();
        req_t r;
        r = '0;
        r.mode = 1'b0;
        r.block_index = BLK_W'($urandom);   // ignored, but toggles bits
        r.slot_index  = SLOT_W'($urandom);
        queue_request(r);
    endtask

    task automatic queue_free(input int b, input int s);
        req_t r;
        r.mode = 1'b1;
        r.block_index = BLK_W'(b);
        r.slot_index  = SLOT_W'(s);
        queue_request(r);
    endtask

    // Free a random live slot (or a random one when none is held).
    task automatic queue_live_free();
        int k;
        if (live_blk.size() == 0)
            queue_free($urandom_range(0, 63), $urandom_range(0, 63));
        else
        begin
            k = $urandom_range(0, live_blk.size() - 1);
            queue_free(live_blk[k], live_slot[k]);
        end
    endtask

    // ---------------------------------------------------------------
    // Config port
    // ---------------------------------------------------------------
    task automatic write_opb(input logic [OPB_W-1:0] v);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(REG_OPB) << 2;
        pwdata  <= 32'(v);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sh_opb = v;
    endtask

    // Wait for the unit to drain; a free of a block needs no extra time after
    // its response, but the extra cycles cover the longest sequencer path.
    task automatic wait_drained();
        while (pending_q.size() != 0 || grant_q.size() != 0) @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    // ---------------------------------------------------------------
    // Driver: bursts with random gaps
    // ---------------------------------------------------------------
    int  burst_left;
    int  gap_left;
    bit  hold_off;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid  <= 1'b0;
            req        <= '0;
            burst_left <= 0;
            gap_left   <= 0;
        end
        else
        begin
            // current request accepted: drop it from the queue
            if (req_valid && !req_stall) void'(pending_q.pop_front());
            if (req_valid && req_stall)
            begin
                // hold payload
            end
            else if (hold_off || pending_q.size() == 0)
                req_valid <= 1'b0;
            else if (gap_left > 0)
            begin
                gap_left  <= gap_left - 1;
                req_valid <= 1'b0;
            end
            else
            begin
                // head of the queue is the next request to send
                req_valid <= 1'b1;
                req       <= pending_q[0];
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
                end
                else
                    burst_left <= burst_left - 1;
            end
        end
    end

    // ---------------------------------------------------------------
    // Monitor and response stall pattern
    // ---------------------------------------------------------------
    int stall_phase;
    int stall_mode;

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            rsp_stall   <= 1'b0;
            stall_phase <= 0;
            stall_mode  <= 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (grant_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected response %p at cycle %0d", rsp, cycle_count);
                end
                else
                begin
                    want = grant_q.pop_front();
                    if (rsp.status !== want.status ||
                        rsp.granted_block !== want.granted_block ||
                        rsp.granted_slot !== want.granted_slot ||
                        rsp.block_released !== want.block_released)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("response mismatch: expected %p, got %p", want, rsp);
                    end
                end
            end
            // stall pattern: long windows of none, some, or heavy stalling
            stall_phase <= stall_phase + 1;
            if (stall_phase % 200 == 0) stall_mode <= $urandom_range(0, 2);
            case (stall_mode)
                0:       rsp_stall <= 1'b0;
                1:       rsp_stall <= ($urandom_range(0, 3) == 0);
                default: rsp_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    initial
    begin
        int k;
        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        hold_off    = 1'b0;
        mismatches  = 0;
        cycle_count = 0;
        shadow_reset();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (80) @(posedge clk);   // list init pass after reset

        // directed: fresh block, invalid frees of each kind, fill and drain
        queue_alloc();
        queue_free(0, 0);           // valid, block goes back to empty
        queue_free(0, 0);           // empty block: invalid
        queue_free(5, 3);           // unused block: invalid
        queue_alloc();
        queue_alloc();
        queue_free(0, 1);
        queue_free(0, 1);           // already free: invalid
        queue_free(0, 63);          // top slot, already free: invalid
        queue_free(63, 63);
        queue_free(0, 0);           // last held slot: block all-free
        wait_drained();

        // slot range edges with 32 slots, then out-of-range settings
        write_opb(OPB_W'(32));
        for (k = 0; k < 33; k++) queue_alloc();   // fills a block: full list
        queue_free(0, 32);          // slot past the count: invalid
        queue_free(0, 31);          // full -> partial
        wait_drained();
        write_opb(OPB_W'(127));     // clamped to 64
        queue_free(0, 0);
        queue_alloc();
        wait_drained();
        write_opb(OPB_W'(0));       // clamped to 32
        queue_alloc();
        wait_drained();

        // random phases: alloc-heavy, almost all allocs, and free-heavy drains
        for (int ph = 0; ph < 6; ph++)
        begin
            write_opb((ph == 2) ? OPB_W'(32) : (ph == 4) ? OPB_W'(64) :
                      OPB_W'($urandom_range(0, 127)));
            for (int i = 0; i < 70; i++)
            begin
                if (ph == 1 && i == 35)
                begin
                    // sender pauses until every sent request has its response
                    repeat (30) @(posedge clk);
                    hold_off = 1'b1;
                    while (grant_q.size() != pending_q.size()) @(posedge clk);
                    hold_off = 1'b0;
                end
                k = $urandom_range(0, 99);
                if (ph == 3)
                begin
                    if (k < 97) queue_alloc(); else queue_live_free();
                end
                else if (k < ((ph % 2) ? 30 : 60)) queue_alloc();
                else if (k < 95) queue_live_free();
                else queue_free($urandom_range(0, 63), $urandom_range(0, 63));
            end
            wait_drained();
        end
        // release all live slots to exercise the trim rule
        while (live_blk.size() != 0) queue_live_free();
        wait_drained();

        if (mismatches == 0 && grant_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
